/* hdl/ss_pkg.sv */
`timescale 1ns / 1ps

package ss_pkg;

    // Width of one element of the set.
    localparam int DATA_W = 32;

    // Default capacity of the element store.
    localparam int DEF_MAX_ELEMS = 64;

    // Controller states.
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PREP,
        ST_CHECK,
        ST_B_LD,
        ST_B_STEP,
        ST_B_END,
        ST_F_RD,
        ST_F_LD,
        ST_F_STEP,
        ST_F_END,
        ST_E_OUT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_LOAD,
        OP_INIT,
        OP_B_START,
        OP_B_LOAD,
        OP_B_STEP,
        OP_B_END,
        OP_F_START,
        OP_F_SKIP,
        OP_F_LOAD,
        OP_F_STEP,
        OP_F_END,
        OP_EMIT_START,
        OP_EMIT_NEXT,
        OP_EMIT_DONE
    } dp_op_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic low_lt_high;
        logic j_m1_is_low;
        logic j_p1_is_high;
        logic emit_last;
    } dp_status_t;

endpackage

/* hdl/ss_ctrl.sv */
`timescale 1ns / 1ps

module ss_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_last,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ss_pkg::dp_status_t status,
    output ss_pkg::dp_op_t     op
);

    ss_pkg::ctrl_state_t state_reg;
    ss_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ss_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ss_pkg::ST_LOAD:
            begin
                if (in_valid && (status.full || in_last))
                begin
                    state_next = ss_pkg::ST_PREP;
                end
            end
            ss_pkg::ST_PREP:
            begin
                state_next = ss_pkg::ST_CHECK;
            end
            ss_pkg::ST_CHECK:
            begin
                state_next = status.low_lt_high ? ss_pkg::ST_B_LD : ss_pkg::ST_E_OUT;
            end
            ss_pkg::ST_B_LD:
            begin
                state_next = ss_pkg::ST_B_STEP;
            end
            ss_pkg::ST_B_STEP:
            begin
                if (status.j_m1_is_low)
                begin
                    state_next = ss_pkg::ST_B_END;
                end
            end
            ss_pkg::ST_B_END:
            begin
                state_next = ss_pkg::ST_F_RD;
            end
            ss_pkg::ST_F_RD:
            begin
                state_next = status.low_lt_high ? ss_pkg::ST_F_LD : ss_pkg::ST_CHECK;
            end
            ss_pkg::ST_F_LD:
            begin
                state_next = ss_pkg::ST_F_STEP;
            end
            ss_pkg::ST_F_STEP:
            begin
                if (status.j_p1_is_high)
                begin
                    state_next = ss_pkg::ST_F_END;
                end
            end
            ss_pkg::ST_F_END:
            begin
                state_next = ss_pkg::ST_CHECK;
            end
            ss_pkg::ST_E_OUT:
            begin
                if (out_ready && status.emit_last)
                begin
                    state_next = ss_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = ss_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        op        = ss_pkg::OP_IDLE;
        case (state_reg)
            ss_pkg::ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid && !status.full)
                begin
                    op = ss_pkg::OP_LOAD;
                end
            end
            ss_pkg::ST_PREP:
            begin
                op = ss_pkg::OP_INIT;
            end
            ss_pkg::ST_CHECK:
            begin
                op = status.low_lt_high ? ss_pkg::OP_B_START : ss_pkg::OP_EMIT_START;
            end
            ss_pkg::ST_B_LD:
            begin
                op = ss_pkg::OP_B_LOAD;
            end
            ss_pkg::ST_B_STEP:
            begin
                op = ss_pkg::OP_B_STEP;
            end
            ss_pkg::ST_B_END:
            begin
                op = ss_pkg::OP_B_END;
            end
            ss_pkg::ST_F_RD:
            begin
                op = status.low_lt_high ? ss_pkg::OP_F_START : ss_pkg::OP_F_SKIP;
            end
            ss_pkg::ST_F_LD:
            begin
                op = ss_pkg::OP_F_LOAD;
            end
            ss_pkg::ST_F_STEP:
            begin
                op = ss_pkg::OP_F_STEP;
            end
            ss_pkg::ST_F_END:
            begin
                op = ss_pkg::OP_F_END;
            end
            ss_pkg::ST_E_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    op = status.emit_last ? ss_pkg::OP_EMIT_DONE : ss_pkg::OP_EMIT_NEXT;
                end
            end
            default:
            begin
                op = ss_pkg::OP_IDLE;
            end
        endcase
    end

endmodule

/* hdl/ss_dpath.sv */
`timescale 1ns / 1ps

module ss_dpath
#(
    parameter int MAX_ELEMS = ss_pkg::DEF_MAX_ELEMS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ss_pkg::dp_op_t                   op,
    input  logic signed [ss_pkg::DATA_W-1:0] in_value,
    output logic signed [ss_pkg::DATA_W-1:0] out_value,
    output logic                             out_final,
    output ss_pkg::dp_status_t               status
);

    localparam int DW = ss_pkg::DATA_W;
    localparam int AW = $clog2(MAX_ELEMS);
    localparam int CW = $clog2(MAX_ELEMS + 1);

    logic signed [DW-1:0] mem [MAX_ELEMS];
    logic signed [DW-1:0] rdata_reg;
    logic signed [DW-1:0] carry_reg;
    logic signed [DW-1:0] carry_next;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] low_reg, low_next;
    logic [AW-1:0] high_reg, high_next;
    logic [AW-1:0] last_reg, last_next;
    logic [AW-1:0] j_reg, j_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] count_m1;
    logic [AW-1:0] j_m1, j_m2, j_p1, j_p2;
    logic          swap_b, swap_f;

    assign count_m1 = count_reg - CW'(1);
    assign j_m1     = j_reg - AW'(1);
    assign j_m2     = j_reg - AW'(2);
    assign j_p1     = j_reg + AW'(1);
    assign j_p2     = j_reg + AW'(2);

    // The carried element is the one bubbling toward the current bound.
    assign swap_b = carry_reg < rdata_reg;
    assign swap_f = rdata_reg < carry_reg;

    assign status.full         = (count_reg == CW'(MAX_ELEMS));
    assign status.low_lt_high  = (low_reg < high_reg);
    assign status.j_m1_is_low  = (j_m1 == low_reg);
    assign status.j_p1_is_high = (j_p1 == high_reg);
    assign status.emit_last    = (CW'(j_reg) == count_m1);

    assign out_value = rdata_reg;
    assign out_final = status.emit_last;

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        last_next  = last_reg;
        j_next     = j_reg;
        carry_next = carry_reg;
        wr_en      = 1'b0;
        wr_addr    = j_reg;
        wr_data    = carry_reg;
        rd_en      = 1'b0;
        rd_addr    = j_reg;
        case (op)
            ss_pkg::OP_LOAD:
            begin
                wr_en      = 1'b1;
                wr_addr    = count_reg[AW-1:0];
                wr_data    = in_value;
                count_next = count_reg + CW'(1);
            end
            ss_pkg::OP_INIT:
            begin
                low_next  = '0;
                high_next = count_m1[AW-1:0];
                last_next = '0;
            end
            ss_pkg::OP_B_START:
            begin
                j_next  = high_reg;
                rd_en   = 1'b1;
                rd_addr = high_reg;
            end
            ss_pkg::OP_B_LOAD:
            begin
                carry_next = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = j_m1;
            end
            ss_pkg::OP_B_STEP:
            begin
                wr_en      = 1'b1;
                wr_data    = swap_b ? rdata_reg : carry_reg;
                carry_next = swap_b ? carry_reg : rdata_reg;
                if (swap_b)
                begin
                    last_next = j_reg;
                end
                j_next  = j_m1;
                rd_en   = !status.j_m1_is_low;
                rd_addr = j_m2;
            end
            ss_pkg::OP_B_END:
            begin
                wr_en    = 1'b1;
                low_next = last_reg;
            end
            ss_pkg::OP_F_START:
            begin
                j_next  = low_reg;
                rd_en   = 1'b1;
                rd_addr = low_reg;
            end
            ss_pkg::OP_F_SKIP:
            begin
                high_next = last_reg;
            end
            ss_pkg::OP_F_LOAD:
            begin
                carry_next = rdata_reg;
                rd_en      = 1'b1;
                rd_addr    = j_p1;
            end
            ss_pkg::OP_F_STEP:
            begin
                wr_en      = 1'b1;
                wr_data    = swap_f ? rdata_reg : carry_reg;
                carry_next = swap_f ? carry_reg : rdata_reg;
                if (swap_f)
                begin
                    last_next = j_reg;
                end
                j_next  = j_p1;
                rd_en   = !status.j_p1_is_high;
                rd_addr = j_p2;
            end
            ss_pkg::OP_F_END:
            begin
                wr_en     = 1'b1;
                high_next = last_reg;
            end
            ss_pkg::OP_EMIT_START:
            begin
                j_next  = '0;
                rd_en   = 1'b1;
                rd_addr = '0;
            end
            ss_pkg::OP_EMIT_NEXT:
            begin
                j_next  = j_p1;
                rd_en   = 1'b1;
                rd_addr = j_p1;
            end
            ss_pkg::OP_EMIT_DONE:
            begin
                count_next = '0;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
        carry_reg <= carry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            low_reg   <= '0;
            high_reg  <= '0;
            last_reg  <= '0;
            j_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            last_reg  <= last_next;
            j_reg     <= j_next;
        end
    end

endmodule

/* hdl/shaker_sort.sv */
`timescale 1ns / 1ps

// Channel   Dir  tdata                       tlast
// s_axis    in   [31:0] item_value (signed)  is_last
// m_axis    out  [31:0] sorted_value (signed) final_flag
//
// Loading takes one transfer per cycle. A closed set of n elements is sorted by
// alternating bubble passes; each pass has two read-ahead steps, then one
// compare-and-write per step beside the next read, then one closing write. The
// sorted set drains at one transfer per cycle while the receiver is ready. Reset
// clears the state, counters and bounds but not the store. An output stall
// holds the current result; no input is taken until the sorted set has drained.
module shaker_sort
#(
    parameter int MAX_ELEMS = ss_pkg::DEF_MAX_ELEMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Input stream.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [ss_pkg::DATA_W-1:0] s_tdata,   // [31:0] item_value
    input  logic                      s_tlast,   // is_last
    // Output stream.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [ss_pkg::DATA_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                      m_tlast    // final_flag
);

    ss_pkg::dp_op_t     op;
    ss_pkg::dp_status_t status;

    logic signed [ss_pkg::DATA_W-1:0] out_value;

    // The controller sequences loading, the sort passes and the drain.
    ss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .op        (op)
    );

    // The datapath holds the store, the bounds and the compare-and-swap unit.
    ss_dpath
    #(
        .MAX_ELEMS (MAX_ELEMS)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .in_value  ($signed(s_tdata)),
        .out_value (out_value),
        .out_final (m_tlast),
        .status    (status)
    );

    assign m_tdata = $unsigned(out_value);

endmodule

/* verif/shaker_sort_checker.sv */
`timescale 1ns / 1ps

// Watches both streams of the sorter, keeps its own copy of the set being
// loaded and queues the sorted values that each closed set must produce.
module shaker_sort_checker
#(
    parameter int MAX_ELEMS = ss_pkg::DEF_MAX_ELEMS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [ss_pkg::DATA_W-1:0] s_tdata,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [ss_pkg::DATA_W-1:0] m_tdata,
    input  logic                      m_tlast,
    output int                        mismatch_count,
    output int                        results_due
);

    typedef struct packed {
        logic [ss_pkg::DATA_W-1:0] value;
        logic                      final_flag;
    } sorted_elem_t;

    logic signed [ss_pkg::DATA_W-1:0] held_set [MAX_ELEMS];
    int                               held_count;
    sorted_elem_t                     sorted_due [$];

    // Cocktail shaker sort of the first n held elements, with bounds that
    // shrink to the place of the last exchange of each pass.
    function automatic void shake_held_set(int n);
        int                               lo;
        int                               hi;
        int                               last_sw;
        int                               j;
        logic signed [ss_pkg::DATA_W-1:0] t;
        lo = 0;
        hi = (n > 0) ? n - 1 : 0;
        last_sw = 0;
        while (lo < hi)
        begin
            for (j = hi; j > lo; j--)
            begin
                if (held_set[j] < held_set[j-1])
                begin
                    t = held_set[j];
                    held_set[j] = held_set[j-1];
                    held_set[j-1] = t;
                    last_sw = j;
                end
            end
            lo = last_sw;
            for (j = lo; j < hi; j++)
            begin
                if (held_set[j+1] < held_set[j])
                begin
                    t = held_set[j];
                    held_set[j] = held_set[j+1];
                    held_set[j+1] = t;
                    last_sw = j;
                end
            end
            hi = last_sw;
        end
    endfunction

    // A transfer into a full store is dropped but still closes the set.
    task automatic take_element(input logic [ss_pkg::DATA_W-1:0] v, input logic closes);
        int i;
        if (held_count < MAX_ELEMS)
        begin
            held_set[held_count] = v;
            held_count++;
            if (!closes)
                return;
        end
        shake_held_set(held_count);
        for (i = 0; i < held_count; i++)
            sorted_due.push_back('{value: held_set[i], final_flag: (i == held_count - 1)});
        held_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sorted_elem_t want;
        if (!rst_n)
        begin
            held_count = 0;
            sorted_due.delete();
            results_due = 0;
            mismatch_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                take_element(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (sorted_due.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("%t: unexpected result value=%0d last=%b",
                                 $realtime, $signed(m_tdata), m_tlast);
                    mismatch_count++;
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.final_flag)
                    begin
                        if (mismatch_count < 10)
                            $display("%t: expected value=%0d last=%b, got value=%0d last=%b",
                                     $realtime, $signed(want.value), want.final_flag,
                                     $signed(m_tdata), m_tlast);
                        mismatch_count++;
                    end
                end
            end
            results_due = sorted_due.size();
        end
    end

endmodule

/* verif/shaker_sort_tb.sv */
`timescale 1ns / 1ps

// Top of the sorter testbench. This module only makes stimulus and gives the
// verdict; all prediction and comparison lives in the checker beside the block.
module shaker_sort_tb;

    localparam int MAX_ELEMS = ss_pkg::DEF_MAX_ELEMS;
    // Length of the one long hold on the output side, in clock cycles.
    localparam int RX_HOLD_CYCLES = 400;
    // Quiet cycles allowed after the last result before the verdict.
    localparam int SETTLE_CYCLES = 50;
    localparam int RANDOM_ITEMS = 150;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [ss_pkg::DATA_W-1:0] s_tdata = '0;
    logic                      s_tlast = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [ss_pkg::DATA_W-1:0] m_tdata;
    logic                      m_tlast;

    int mismatch_count;
    int results_due;

    // When clear, neither side inserts gaps, so both streams run back to back.
    bit idle_on = 1'b1;
    // Set by the stimulus to request one long hold-off from the receiver.
    bit hold_rx = 1'b0;
    // Set by the receiver once that hold-off has begun.
    bit hold_started = 1'b0;
    int random_sent;

    always #1 clk = ~clk;

    shaker_sort #(
        .MAX_ELEMS(MAX_ELEMS)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    shaker_sort_checker #(
        .MAX_ELEMS(MAX_ELEMS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .mismatch_count(mismatch_count),
        .results_due   (results_due)
    );

    // Gap length shared by both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Element values: full-range random, a narrow band around zero so that
    // duplicates are common, and the corner patterns of a signed word.
    function automatic logic [ss_pkg::DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom();
        if (r < 80)
            return $urandom_range(0, 16) - 8;
        case ($urandom_range(0, 6))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4: return 32'h0000_0001;
            5: return 32'h8000_0001;
            default: return 32'h7FFF_FFFE;
        endcase
    endfunction

    // Offers one element and returns at the clock edge of its transfer. The
    // valid stays high afterwards so that back-to-back elements need no
    // second assignment in one time step; stop_offering lowers it.
    task automatic offer_element(input logic [ss_pkg::DATA_W-1:0] v, input logic closes);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= closes;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic stop_offering();
        s_tvalid <= 1'b0;
    endtask

    // Sends a set of n random elements, marking the last one only if asked.
    task automatic offer_set(input int n, input bit mark_last);
        int i;
        for (i = 0; i < n; i++)
            offer_element(pick_value(), mark_last && (i == n - 1));
        random_sent += n;
    endtask

    // Waits until every predicted result has been taken by the receiver.
    task automatic wait_drained();
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
    endtask

    // Receiver: one ready level per stretch, so the ready gets at most one
    // assignment per time step. A pending hold request wins over idling.
    initial
    begin : receiver
        logic level;
        int   len;
        wait (rst_n);
        forever
        begin
            if (hold_rx && !hold_started)
            begin
                level = 1'b0;
                len = RX_HOLD_CYCLES;
                hold_started = 1'b1;
            end
            else
            begin
                len = pick_gap();
                level = (len == 0);
                if (level)
                    len = $urandom_range(1, 12);
            end
            m_tready <= level;
            repeat (len) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int r;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets: one-element sets at both ends of the signed range,
        // a reversed pair of extremes, equal values, and alternating bits.
        offer_element(32'h7FFF_FFFF, 1'b1);
        offer_element(32'h8000_0000, 1'b1);
        offer_element(32'h7FFF_FFFF, 1'b0);
        offer_element(32'h8000_0000, 1'b1);
        offer_element(32'd5, 1'b0);
        offer_element(32'd5, 1'b0);
        offer_element(-32'sd5, 1'b0);
        offer_element(32'd5, 1'b1);
        offer_element(32'hAAAA_AAAA, 1'b0);
        offer_element(32'h5555_5555, 1'b0);
        offer_element(32'h0000_0000, 1'b0);
        offer_element(32'hFFFF_FFFF, 1'b1);

        // The sender pauses here until the whole directed output is back.
        stop_offering();
        wait_drained();

        // A set that exactly fills the store, sent with no idling at all.
        random_sent = 0;
        idle_on = 1'b0;
        offer_set(MAX_ELEMS, 1'b1);
        stop_offering();
        wait_drained();

        // The receiver holds off for a long stretch while a small set is
        // sorted and a second one is offered; the block cannot take the
        // second set until the first has drained, so its input stalls.
        hold_rx = 1'b1;
        wait (hold_started);
        offer_set(6, 1'b1);
        idle_on = 1'b1;
        offer_set(5, 1'b1);

        // Overflow: a full store without a closing mark, then one more
        // element that is dropped and closes the set whatever its mark.
        offer_set(MAX_ELEMS, 1'b0);
        offer_element(pick_value(), 1'($urandom_range(0, 1)));

        // Random sets, mostly small, with stretches with and without idling.
        while (random_sent < RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 85)
                offer_set($urandom_range(1, 8), 1'b1);
            else if (r < 97)
                offer_set($urandom_range(9, 24), 1'b1);
            else
                offer_set(MAX_ELEMS, 1'b1);
        end

        stop_offering();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_due == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Safety net far above the slowest correct run.
    initial
    begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* shaker_sort.f */
hdl/ss_pkg.sv
hdl/ss_ctrl.sv
hdl/ss_dpath.sv
hdl/shaker_sort.sv
verif/shaker_sort_checker.sv
verif/shaker_sort_tb.sv
